>>> src/cbls_pkg.sv
// Shared types and constants of the clamped Bresenham line stepper.
package cbls_pkg;

  // Widths fixed by the item and register formats.
  localparam int CfgW   = 13;
  localparam int CoordInW = 16;

  // Signed width used for clamping: holds any input coordinate and any size.
  localparam int CmpW = 18;

  // Screen size after reset.
  localparam logic [CfgW-1:0] WidthReset  = 13'd640;
  localparam logic [CfgW-1:0] HeightReset = 13'd480;

  // Operation carried by each input item.
  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_index_e;

endpackage

>>> src/clamped_bresenham_line_stepper.sv
// Clamped Bresenham line stepper. A load item (operation 0) clamps both end
// points into the screen and replaces any active line; a step item
// (operation 1) yields the next pixel of the active line, with last_pixel set
// on the end point, or nothing if no line is active. A zero length line gives
// no pixels. The block sustains one item per clock while out_ready_i holds:
// the front end takes an item into a two entry queue in the cycle it is
// accepted, the back end performs a load or a step as it leaves the queue,
// and a pixel sits in the output register from the cycle after its step
// leaves the queue. The single stepping unit and the one output register set
// that rate. Screen size writes take effect at once and should only be made
// while no item is in flight; no clearing pass runs after reset.
module clamped_bresenham_line_stepper #(
  parameter int MAX_SCREEN = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_index_i,
  input  logic [cbls_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operation_i,
  input  logic signed [cbls_pkg::CoordInW-1:0] start_x_i,
  input  logic signed [cbls_pkg::CoordInW-1:0] start_y_i,
  input  logic signed [cbls_pkg::CoordInW-1:0] end_x_i,
  input  logic signed [cbls_pkg::CoordInW-1:0] end_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [$clog2(MAX_SCREEN)-1:0]        pixel_x_o,
  output logic [$clog2(MAX_SCREEN)-1:0]        pixel_y_o,
  output logic                                 last_pixel_o
);

  localparam int CoordW     = $clog2(MAX_SCREEN);
  localparam int QueueW     = 4 * CoordW + 1;
  localparam int QueueDepth = 2;

  logic              q_push, q_full, q_valid, q_pop;
  logic [QueueW-1:0] q_wdata, q_rdata;

  // Intake and clamping.
  cbls_front #(
    .MAX_SCREEN(MAX_SCREEN),
    .CoordW    (CoordW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // Queue between the two halves.
  cbls_fifo #(
    .Width(QueueW),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .data_o     (q_rdata),
    .pop_i      (q_pop)
  );

  // Setup, stepping and result register.
  cbls_back #(
    .CoordW(CoordW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_pixel_o(last_pixel_o)
  );

endmodule

>>> src/cbls_fifo.sv
// Small register queue between the front end and the back end.
module cbls_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  input  logic             pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; no reset needed for payload.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/cbls_front.sv
// Front end: screen size registers, item intake and end point clamping.
module cbls_front #(
  parameter int MAX_SCREEN = 4096,
  parameter int CoordW = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_index_i,
  input  logic [cbls_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             operation_i,
  input  logic signed [cbls_pkg::CoordInW-1:0] start_x_i,
  input  logic signed [cbls_pkg::CoordInW-1:0] start_y_i,
  input  logic signed [cbls_pkg::CoordInW-1:0] end_x_i,
  input  logic signed [cbls_pkg::CoordInW-1:0] end_y_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output logic [4*CoordW:0]                q_data_o
);

  localparam int CmpW = cbls_pkg::CmpW;
  localparam logic signed [CmpW-1:0] MaxSize = CmpW'(MAX_SCREEN);

  logic [cbls_pkg::CfgW-1:0] width_q, height_q;
  logic signed [CmpW-1:0]    eff_width, eff_height;
  logic [CoordW-1:0]         sx, sy, ex, ey;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cbls_pkg::WidthReset;
      height_q <= cbls_pkg::HeightReset;
    end else if (cfg_we_i) begin
      case (cbls_pkg::cfg_index_e'(cfg_index_i))
        cbls_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        cbls_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A size of zero acts as one; sizes above the maximum act as the maximum.
  function automatic logic signed [CmpW-1:0] eff_size(
    input logic [cbls_pkg::CfgW-1:0] size
  );
    logic signed [CmpW-1:0] ext;
    ext = $signed(CmpW'(size));
    if (size == '0) begin
      return CmpW'(1);
    end else if (ext > MaxSize) begin
      return MaxSize;
    end
    return ext;
  endfunction

  // Clamp a signed coordinate into 0 .. size-1.
  function automatic logic [CoordW-1:0] clamp(
    input logic signed [cbls_pkg::CoordInW-1:0] v,
    input logic signed [CmpW-1:0]               size
  );
    logic signed [CmpW-1:0] ext;
    logic signed [CmpW-1:0] res;
    ext = CmpW'(v);
    if (ext < 0) begin
      res = '0;
    end else if (ext >= size) begin
      res = size - CmpW'(1);
    end else begin
      res = ext;
    end
    return res[CoordW-1:0];
  endfunction

  assign eff_width  = eff_size(width_q);
  assign eff_height = eff_size(height_q);
  assign sx = clamp(start_x_i, eff_width);
  assign sy = clamp(start_y_i, eff_height);
  assign ex = clamp(end_x_i, eff_width);
  assign ey = clamp(end_y_i, eff_height);

  // Every accepted item goes into the queue; step items carry unused points.
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_data_o   = {operation_i, sx, sy, ex, ey};

endmodule

>>> src/cbls_back.sv
// Back end: line setup, Bresenham stepping and the result register.
module cbls_back #(
  parameter int CoordW = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  logic [4*CoordW:0] q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] pixel_x_o,
  output logic [CoordW-1:0] pixel_y_o,
  output logic              last_pixel_o
);

  localparam int DW   = CoordW + 1;
  localparam int DecW = CoordW + 3;
  localparam int StW  = CoordW + 1;

  cbls_pkg::op_e     head_op;
  logic [CoordW-1:0] sx, sy, ex, ey;

  // Line state.
  logic [CoordW-1:0]      cur_x_q, cur_y_q;
  logic signed [DecW-1:0] dec_q, inc_pos_q, inc_neg_q;
  logic [StW-1:0]         steps_q;
  logic                   x_neg_q, y_neg_q, steep_q, active_q;

  // Result register.
  logic              out_valid_q;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic              out_last_q;

  // Setup values.
  logic signed [DW-1:0] dx, dy;
  logic [CoordW-1:0]    adx, ady, major, minor;
  logic                 steep;
  logic [DecW-1:0]      two_minor, two_major;

  // Step values.
  logic              do_load, do_step, emit, dec_le_zero;
  logic [CoordW-1:0] x_move, y_move;

  assign head_op = cbls_pkg::op_e'(q_data_i[4*CoordW]);
  assign sx = q_data_i[4*CoordW-1 -: CoordW];
  assign sy = q_data_i[3*CoordW-1 -: CoordW];
  assign ex = q_data_i[2*CoordW-1 -: CoordW];
  assign ey = q_data_i[CoordW-1 -: CoordW];

  // A load never needs the result register; a step needs it free.
  assign q_pop_o = q_valid_i &&
                   (head_op == cbls_pkg::OP_LOAD || !out_valid_q || out_ready_i);
  assign do_load = q_pop_o && head_op == cbls_pkg::OP_LOAD;
  assign do_step = q_pop_o && head_op == cbls_pkg::OP_STEP;
  assign emit    = do_step && active_q;

  // Deltas, directions and branch choice for a new line.
  always_comb begin
    dx        = $signed({1'b0, ex}) - $signed({1'b0, sx});
    dy        = $signed({1'b0, ey}) - $signed({1'b0, sy});
    adx       = dx[DW-1] ? CoordW'(-dx) : dx[CoordW-1:0];
    ady       = dy[DW-1] ? CoordW'(-dy) : dy[CoordW-1:0];
    steep     = ady > adx;
    major     = steep ? ady : adx;
    minor     = steep ? adx : ady;
    two_minor = {2'b00, minor, 1'b0};
    two_major = {2'b00, major, 1'b0};
  end

  // One pixel move along each axis in its direction.
  assign x_move      = x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
  assign y_move      = y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
  assign dec_le_zero = dec_q[DecW-1] || (dec_q == '0);

  // Line state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      dec_q     <= '0;
      inc_pos_q <= '0;
      inc_neg_q <= '0;
      steps_q   <= '0;
      x_neg_q   <= 1'b0;
      y_neg_q   <= 1'b0;
      steep_q   <= 1'b0;
      active_q  <= 1'b0;
    end else if (do_load) begin
      cur_x_q   <= sx;
      cur_y_q   <= sy;
      x_neg_q   <= dx[DW-1];
      y_neg_q   <= dy[DW-1];
      steep_q   <= steep;
      dec_q     <= $signed(two_minor) - $signed({3'b000, major});
      inc_pos_q <= $signed(two_minor);
      inc_neg_q <= $signed(two_minor) - $signed(two_major);
      steps_q   <= {1'b0, major} + 1'b1;
      active_q  <= (major != '0);
    end else if (emit) begin
      // The major axis always moves; the minor axis moves on a positive term.
      if (steep_q) begin
        cur_y_q <= y_move;
        if (!dec_le_zero) begin
          cur_x_q <= x_move;
        end
      end else begin
        cur_x_q <= x_move;
        if (!dec_le_zero) begin
          cur_y_q <= y_move;
        end
      end
      dec_q    <= dec_q + (dec_le_zero ? inc_pos_q : inc_neg_q);
      steps_q  <= steps_q - 1'b1;
      active_q <= (steps_q != StW'(1));
    end
  end

  // Result register handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q    <= cur_x_q;
      out_y_q    <= cur_y_q;
      out_last_q <= (steps_q == StW'(1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = out_x_q;
  assign pixel_y_o    = out_y_q;
  assign last_pixel_o = out_last_q;

endmodule

>>> src/cbls_checker.sv
// Port level checks of the line stepper and their bind to the top level.
module cbls_checker #(
  parameter int MAX_SCREEN = 4096
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          operation_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [$clog2(MAX_SCREEN)-1:0] pixel_x_o,
  input logic [$clog2(MAX_SCREEN)-1:0] pixel_y_o,
  input logic                          last_pixel_o
);

  logic        step_acc, out_acc;
  logic [31:0] pending_q;

  assign step_acc = in_valid_i && in_ready_o && (operation_i == cbls_pkg::OP_STEP);
  assign out_acc  = out_valid_o && out_ready_i;

  // Step items taken minus pixels delivered; never below the true backlog.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (step_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !step_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // A stalled pixel holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_x_o) &&
    $stable(pixel_y_o) && $stable(last_pixel_o))
    else $error("pixel changed while stalled");

  // Every pixel shown is owed to an earlier step item.
  a_out_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("pixel without a step item");

  // A new pixel appears only after its step item has been counted.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pending_q) != '0)
    else $error("pixel appeared too early");

  // Once the last owed pixel is taken and no step arrives, the output empties.
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && pending_q == 32'd1 && !step_acc |=> !out_valid_o)
    else $error("extra pixel after backlog drained");

endmodule

bind clamped_bresenham_line_stepper cbls_checker #(
  .MAX_SCREEN(MAX_SCREEN)
) u_cbls_checker (.*);
